// ----- sv/minmax_decimating_trace_renderer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min/max trace renderer
// Each macro expects signals named clk and rst_n in the calling module.
// ----------------------------------------------------------------------------
`ifndef MINMAX_DECIMATING_TRACE_RENDERER_UNIT_MACROS_SVH
`define MINMAX_DECIMATING_TRACE_RENDERER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MDTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MDTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mdtr_pkg.sv -----
// ----------------------------------------------------------------------------
// mdtr_pkg
// Shared types, widths and register indices for the min/max trace renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdtr_pkg;

  // Field widths
  localparam int SAMPLE_BITS    = 16;
  localparam int COL_BITS       = 10;
  localparam int LINE_BITS      = 16;
  localparam int STRIDE_BITS    = 9;
  localparam int GAIN_BITS      = 16;
  localparam int YC_BITS        = 12;
  localparam int NEWEST_BITS    = 16;
  localparam int BUF_POS_BITS   = 16;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Column wrap and default stride limit
  localparam int MAX_COLUMNS     = 1024;
  localparam int MAX_STRIDE_DEF  = 256;

  // Gain is unsigned Q4.12
  localparam int GAIN_FRAC_BITS = 12;
  localparam int PROD_BITS      = GAIN_BITS + 1 + SAMPLE_BITS;
  localparam int SCALED_BITS    = PROD_BITS - GAIN_FRAC_BITS;
  localparam int DIFF_BITS      = SCALED_BITS + 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indices
  localparam logic [CFG_ADDR_BITS-1:0] CFG_STRIDE        = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_GAIN          = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_Y_CENTER      = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_NEWEST_INDEX  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CURSOR_ENABLE = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          restart;
  } in_item_t;

  typedef struct packed {
    logic [COL_BITS-1:0]         column;
    logic signed [LINE_BITS-1:0] line_top;
    logic signed [LINE_BITS-1:0] line_bottom;
    logic                        newest_here;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [STRIDE_BITS-1:0] stride;
    logic [GAIN_BITS-1:0]   gain;
    logic [YC_BITS-1:0]     y_center;
    logic [NEWEST_BITS-1:0] newest_index;
    logic                   cursor_enable;
  } cfg_t;

  // One finished column handed from front to back
  typedef struct packed {
    logic [COL_BITS-1:0]           column;
    logic signed [SAMPLE_BITS-1:0] col_max;
    logic signed [SAMPLE_BITS-1:0] col_min;
    logic                          newest;
  } col_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/mdtr_front.sv -----
// ----------------------------------------------------------------------------
// mdtr_front
// Takes samples, keeps running min/max per column and pushes closed columns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdtr_front #(
  parameter int MAX_STRIDE = mdtr_pkg::MAX_STRIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mdtr_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mdtr_pkg::in_item_t     in_data,
  input  mdtr_pkg::q_status_t    q_status,
  output logic                   push,
  output mdtr_pkg::col_entry_t   push_data
);
  import mdtr_pkg::*;

  localparam int PW = $clog2(MAX_STRIDE + 1);

  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [COL_BITS-1:0]           col_r, col_nxt;
  logic [BUF_POS_BITS-1:0]       buf_r, buf_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                          seen_r, seen_nxt;

  logic [PW-1:0]           eff;
  logic [PW-1:0]           pos_base;
  logic [PW-1:0]           pos_inc;
  logic [COL_BITS-1:0]     col_base;
  logic [BUF_POS_BITS-1:0] buf_base;
  logic                    first;
  logic                    match;
  logic                    done;
  logic                    accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Effective stride: zero acts as one, clamp at the limit
  always_comb begin
    if (cfg.stride == '0) begin
      eff = PW'(1);
    end else if (int'(cfg.stride) > MAX_STRIDE) begin
      eff = PW'(MAX_STRIDE);
    end else begin
      eff = PW'(cfg.stride);
    end
  end

  // Restart drops the partial group before the sample is taken
  assign pos_base = in_data.restart ? '0 : pos_r;
  assign col_base = in_data.restart ? '0 : col_r;
  assign buf_base = in_data.restart ? '0 : buf_r;
  assign first    = (pos_base == '0);
  assign match    = (cfg.newest_index == buf_base);
  assign pos_inc  = pos_base + PW'(1);
  assign done     = (pos_inc >= eff);

  // Running extremes and newest-sample tracking
  always_comb begin
    if (first) begin
      min_nxt  = in_data.sample_value;
      max_nxt  = in_data.sample_value;
      seen_nxt = match;
    end else begin
      min_nxt  = (in_data.sample_value < min_r) ? in_data.sample_value : min_r;
      max_nxt  = (in_data.sample_value > max_r) ? in_data.sample_value : max_r;
      seen_nxt = seen_r || (match && (cfg.newest_index != '0));
    end
  end

  // Position counters
  always_comb begin
    buf_nxt = buf_base + BUF_POS_BITS'(1);
    if (done) begin
      pos_nxt = '0;
      col_nxt = (col_base == COL_BITS'(MAX_COLUMNS - 1)) ? '0 : col_base + COL_BITS'(1);
    end else begin
      pos_nxt = pos_inc;
      col_nxt = col_base;
    end
  end

  // Closed column request
  assign push              = accept && done;
  assign push_data.column  = col_base;
  assign push_data.col_max = max_nxt;
  assign push_data.col_min = min_nxt;
  assign push_data.newest  = cfg.cursor_enable && seen_nxt &&
                             (cfg.newest_index != '0) && (col_base != '0);

  // Control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      col_r <= '0;
      buf_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      buf_r <= buf_nxt;
    end
  end

  // Group payload, reloaded at the first sample of each column
  always_ff @(posedge clk) begin
    if (accept) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- sv/mdtr_queue.sv -----
// ----------------------------------------------------------------------------
// mdtr_queue
// Small FIFO of closed columns between the front and the scaling back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdtr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mdtr_pkg::col_entry_t  push_data,
  input  logic                  pop,
  output mdtr_pkg::col_entry_t  pop_data,
  output mdtr_pkg::q_status_t   status
);
  import mdtr_pkg::*;
  `include "minmax_decimating_trace_renderer_unit_macros.svh"

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  col_entry_t          entry_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Checks
  `MDTR_ASSERT_NOW(a_no_push_full, push, !status.full, "push into full column queue")
  `MDTR_ASSERT_NOW(a_no_pop_empty, pop, !status.empty, "pop from empty column queue")
  `MDTR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_BITS'(QUEUE_DEPTH), "queue count overrun")
  `MDTR_ASSERT_NEXT(a_fill_to_full, push && !pop && (cnt_r == CNT_BITS'(QUEUE_DEPTH - 1)), status.full, "queue did not report full")

endmodule

// ----- sv/mdtr_back.sv -----
// ----------------------------------------------------------------------------
// mdtr_back
// Scales column extremes by the gain, offsets from the centre and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdtr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mdtr_pkg::cfg_t        cfg,
  input  mdtr_pkg::q_status_t   q_status,
  input  mdtr_pkg::col_entry_t  q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mdtr_pkg::out_item_t   out_data
);
  import mdtr_pkg::*;

  // Clamp a wide difference into the line range
  function automatic logic signed [LINE_BITS-1:0] sat_line(
    input logic signed [DIFF_BITS-1:0] d
  );
    logic in_range;
    in_range = (&d[DIFF_BITS-1:LINE_BITS-1]) || !(|d[DIFF_BITS-1:LINE_BITS-1]);
    if (in_range) begin
      return d[LINE_BITS-1:0];
    end else if (d[DIFF_BITS-1]) begin
      return {1'b1, {(LINE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(LINE_BITS-1){1'b1}}};
    end
  endfunction

  logic en;

  // Stage 1: products
  logic                        s1_valid_r;
  logic signed [PROD_BITS-1:0] s1_hi_r, s1_lo_r;
  logic [COL_BITS-1:0]         s1_col_r;
  logic                        s1_newest_r;
  logic signed [PROD_BITS-1:0] gain_ext;

  // Stage 2: scaled ends
  logic                          s2_valid_r;
  logic signed [SCALED_BITS:0]   s2_hi_r;
  logic signed [SCALED_BITS-1:0] s2_lo_r;
  logic [COL_BITS-1:0]           s2_col_r;
  logic                          s2_newest_r;
  logic signed [SCALED_BITS-1:0] hi_scaled, lo_scaled;
  logic signed [SCALED_BITS:0]   hi_adj;

  // Output register
  logic                          out_valid_r;
  out_item_t                     out_data_r;
  logic signed [DIFF_BITS-1:0]   centre_ext;
  logic signed [DIFF_BITS-1:0]   top_diff, bot_diff;

  // Whole pipe moves unless the output holds an untaken result
  assign en        = !out_valid_r || out_ready;
  assign pop       = en && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign gain_ext = $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, cfg.gain});

  // Divide by 4096 truncating toward zero
  assign hi_scaled = (s1_hi_r < 0)
                   ? SCALED_BITS'((s1_hi_r + PROD_BITS'((1 << GAIN_FRAC_BITS) - 1))
                                  >>> GAIN_FRAC_BITS)
                   : SCALED_BITS'(s1_hi_r >>> GAIN_FRAC_BITS);
  assign lo_scaled = (s1_lo_r < 0)
                   ? SCALED_BITS'((s1_lo_r + PROD_BITS'((1 << GAIN_FRAC_BITS) - 1))
                                  >>> GAIN_FRAC_BITS)
                   : SCALED_BITS'(s1_lo_r >>> GAIN_FRAC_BITS);
  // Flat column: lift the top end by one
  assign hi_adj    = (SCALED_BITS + 1)'(hi_scaled) +
                     ((hi_scaled == lo_scaled) ? (SCALED_BITS + 1)'(1)
                                               : (SCALED_BITS + 1)'(0));

  assign centre_ext = $signed({{(DIFF_BITS-YC_BITS){1'b0}}, cfg.y_center});
  assign top_diff   = centre_ext - DIFF_BITS'(s2_hi_r);
  assign bot_diff   = centre_ext - DIFF_BITS'(s2_lo_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_hi_r     <= gain_ext * PROD_BITS'(q_data.col_max);
      s1_lo_r     <= gain_ext * PROD_BITS'(q_data.col_min);
      s1_col_r    <= q_data.column;
      s1_newest_r <= q_data.newest;

      s2_hi_r     <= hi_adj;
      s2_lo_r     <= lo_scaled;
      s2_col_r    <= s1_col_r;
      s2_newest_r <= s1_newest_r;

      out_data_r.column      <= s2_col_r;
      out_data_r.line_top    <= sat_line(top_diff);
      out_data_r.line_bottom <= sat_line(bot_diff);
      out_data_r.newest_here <= s2_newest_r;
    end
  end

endmodule

// ----- sv/minmax_decimating_trace_renderer_unit.sv -----
// Throughput: one sample per cycle while the column queue is not full; one
// column line per cycle at stride one while out_ready holds. A result passes
// through the queue write, the two-stage multiply and scale pipe and the output
// register; a 4-entry column queue lets the sample side run on.
// Synchronous active-low reset returns the registers to their defaults
// (stride one, others zero) and empties the counters, queue and pipe.
// ----------------------------------------------------------------------------
// minmax_decimating_trace_renderer_unit
// Top level: configuration registers, sample front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minmax_decimating_trace_renderer_unit #(
  parameter int MAX_STRIDE = mdtr_pkg::MAX_STRIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mdtr_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [mdtr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mdtr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mdtr_pkg::out_item_t                  out_data
);
  import mdtr_pkg::*;

  cfg_t       cfg_r;
  q_status_t  q_status;
  logic       push;
  logic       pop;
  col_entry_t push_data;
  col_entry_t pop_data;

  // Register writes; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stride        <= STRIDE_BITS'(1);
      cfg_r.gain          <= '0;
      cfg_r.y_center      <= '0;
      cfg_r.newest_index  <= '0;
      cfg_r.cursor_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STRIDE:        cfg_r.stride        <= cfg_wdata[STRIDE_BITS-1:0];
        CFG_GAIN:          cfg_r.gain          <= cfg_wdata[GAIN_BITS-1:0];
        CFG_Y_CENTER:      cfg_r.y_center      <= cfg_wdata[YC_BITS-1:0];
        CFG_NEWEST_INDEX:  cfg_r.newest_index  <= cfg_wdata[NEWEST_BITS-1:0];
        CFG_CURSOR_ENABLE: cfg_r.cursor_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sample side
  mdtr_front #(
    .MAX_STRIDE (MAX_STRIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Closed columns waiting for scaling
  mdtr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Scaling and output
  mdtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
